// ===== design/dusss_pkg.sv =====
// ----------------------------------------------------------------------------
// dusss_pkg
// Shared types, constants and phase tables for the dual unipolar stepper
// sequencer.
// ----------------------------------------------------------------------------
package dusss_pkg;

    // Position width; the saturation limits follow from it
    localparam int POSITION_BITS = 16;
    localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int PRESCALE_W = 8;
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 3;
    localparam int NIBBLE_W   = 4;
    localparam int COIL_W     = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_MASK = 3'd0,
        CFG_MODE_A      = 3'd1,
        CFG_MODE_B      = 3'd2,
        CFG_PRESCALE_A  = 3'd3,
        CFG_PRESCALE_B  = 3'd4
    } t_cfg_idx;

    // Phase table selection
    typedef enum logic [MODE_W-1:0] {
        MODE_ONE_PHASE = 2'd0,
        MODE_TWO_PHASE = 2'd1,
        MODE_HALF_STEP = 2'd2,
        MODE_SPARE     = 2'd3
    } t_phase_mode;

    typedef struct packed {
        logic signed [POSITION_BITS-1:0] target_a;
        logic signed [POSITION_BITS-1:0] target_b;
    } t_in_item;

    typedef struct packed {
        logic [COIL_W-1:0]               coil_drive;
        logic signed [POSITION_BITS-1:0] position_a;
        logic signed [POSITION_BITS-1:0] position_b;
        logic                            at_target_a;
        logic                            at_target_b;
    } t_out_item;

    // Per-motor settings handed to a motor channel
    typedef struct packed {
        logic                  enable;
        logic [MODE_W-1:0]     mode;
        logic [PRESCALE_W-1:0] prescale;
    } t_motor_cfg;

    // Per-motor result of one tick
    typedef struct packed {
        logic [NIBBLE_W-1:0]             nibble;
        logic signed [POSITION_BITS-1:0] pos;
        logic                            at_target;
    } t_motor_res;

    // Coil pattern for a table and an index; the spare mode uses half-step
    function automatic logic [NIBBLE_W-1:0] phase_pattern(
        input logic [MODE_W-1:0] mode,
        input logic [IDX_W-1:0]  idx
    );
        logic [NIBBLE_W-1:0] pat;
        pat = 4'b0001;
        case (mode)
            MODE_ONE_PHASE: begin
                case (idx[1:0])
                    2'd0:    pat = 4'b0001;
                    2'd1:    pat = 4'b0010;
                    2'd2:    pat = 4'b0100;
                    default: pat = 4'b1000;
                endcase
            end
            MODE_TWO_PHASE: begin
                case (idx[1:0])
                    2'd0:    pat = 4'b0011;
                    2'd1:    pat = 4'b0110;
                    2'd2:    pat = 4'b1100;
                    default: pat = 4'b1001;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    pat = 4'b0001;
                    3'd1:    pat = 4'b0011;
                    3'd2:    pat = 4'b0010;
                    3'd3:    pat = 4'b0110;
                    3'd4:    pat = 4'b0100;
                    3'd5:    pat = 4'b1100;
                    3'd6:    pat = 4'b1000;
                    default: pat = 4'b1001;
                endcase
            end
        endcase
        return pat;
    endfunction

endpackage

// ===== design/dual_unipolar_stepper_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// dual_unipolar_stepper_sequencer_top
// Two unipolar stepper motors on one 8-bit coil port, one timer tick per
// transfer, with full-step, two-phase and half-step tables.
//
//   channel  | signals                           | carries
//   ---------+-----------------------------------+---------------------------
//   input    | i_in_valid / o_in_ready / i_in_data  | targets of A and B
//   output   | o_out_valid / i_out_ready / o_out_data | coils, positions, flags
//   config   | i_cfg_we / i_cfg_idx / i_cfg_data | five registers, write only
//
// One tick per cycle while o_in_ready is high: a transfer is worked out in
// the cycle it is accepted; its result is registered in the output register,
// or in a skid register while the output is stalled, so the input stays
// ready while one result is stalled and drops only when both are full.
// Reset is synchronous; the block takes transfers right after it.
// ----------------------------------------------------------------------------
module dual_unipolar_stepper_sequencer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dusss_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dusss_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_we,
    input  logic [dusss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dusss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [1:0]                          r_enable;
    logic [dusss_pkg::MODE_W-1:0]        r_mode_a;
    logic [dusss_pkg::MODE_W-1:0]        r_mode_b;
    logic [dusss_pkg::PRESCALE_W-1:0]    r_pre_a;
    logic [dusss_pkg::PRESCALE_W-1:0]    r_pre_b;

    logic                                w_accept;
    dusss_pkg::t_motor_cfg               w_cfg_a;
    dusss_pkg::t_motor_cfg               w_cfg_b;
    dusss_pkg::t_motor_res               w_res_a;
    dusss_pkg::t_motor_res               w_res_b;
    dusss_pkg::t_out_item                w_result;

    logic                                r_out_valid, n_out_valid;
    logic                                r_skid_valid, n_skid_valid;
    dusss_pkg::t_out_item                r_out_data;
    dusss_pkg::t_out_item                r_skid_data;
    logic                                w_out_free;
    logic                                w_load_out;
    logic                                w_load_skid;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 2'b11;
            r_mode_a <= dusss_pkg::MODE_ONE_PHASE;
            r_mode_b <= dusss_pkg::MODE_ONE_PHASE;
            r_pre_a  <= dusss_pkg::PRESCALE_W'(1);
            r_pre_b  <= dusss_pkg::PRESCALE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dusss_pkg::CFG_ENABLE_MASK: r_enable <= i_cfg_data[1:0];
                dusss_pkg::CFG_MODE_A:      r_mode_a <= i_cfg_data[dusss_pkg::MODE_W-1:0];
                dusss_pkg::CFG_MODE_B:      r_mode_b <= i_cfg_data[dusss_pkg::MODE_W-1:0];
                dusss_pkg::CFG_PRESCALE_A:  r_pre_a  <= i_cfg_data[dusss_pkg::PRESCALE_W-1:0];
                dusss_pkg::CFG_PRESCALE_B:  r_pre_b  <= i_cfg_data[dusss_pkg::PRESCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;

    // Motor settings
    always_comb begin
        w_cfg_a.enable   = r_enable[0];
        w_cfg_a.mode     = r_mode_a;
        w_cfg_a.prescale = r_pre_a;
        w_cfg_b.enable   = r_enable[1];
        w_cfg_b.mode     = r_mode_b;
        w_cfg_b.prescale = r_pre_b;
    end

    dusss_motor u_motor_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_accept),
        .i_cfg    (w_cfg_a),
        .i_target (i_in_data.target_a),
        .o_res    (w_res_a)
    );

    dusss_motor u_motor_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_accept),
        .i_cfg    (w_cfg_b),
        .i_target (i_in_data.target_b),
        .o_res    (w_res_b)
    );

    // Assemble the result of this tick
    always_comb begin
        w_result.coil_drive  = {w_res_b.nibble, w_res_a.nibble};
        w_result.position_a  = w_res_a.pos;
        w_result.position_b  = w_res_b.pos;
        w_result.at_target_a = w_res_a.at_target;
        w_result.at_target_b = w_res_b.at_target;
    end

    // Output register and skid control
    always_comb begin
        w_out_free   = !r_out_valid || i_out_ready;
        w_load_out   = w_out_free && !r_skid_valid && w_accept;
        w_load_skid  = !w_out_free && w_accept;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_free) begin
            n_out_valid  = r_skid_valid || w_accept;
            n_skid_valid = 1'b0;
        end else if (w_accept) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Move payload: skid drains first, else the fresh result
    always_ff @(posedge i_clk) begin
        if (w_out_free && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end else if (w_load_out) begin
            r_out_data <= w_result;
        end
        if (w_load_skid) begin
            r_skid_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/dusss_motor.sv =====
// ----------------------------------------------------------------------------
// dusss_motor
// One motor channel: tick divider, phase index, position and coil nibble.
// ----------------------------------------------------------------------------
module dusss_motor (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_tick,
    input  dusss_pkg::t_motor_cfg                     i_cfg,
    input  logic signed [dusss_pkg::POSITION_BITS-1:0] i_target,
    output dusss_pkg::t_motor_res                     o_res
);

    logic signed [dusss_pkg::POSITION_BITS-1:0] r_pos, n_pos;
    logic [dusss_pkg::IDX_W-1:0]                r_idx, n_idx;
    logic [dusss_pkg::PRESCALE_W-1:0]           r_div, n_div;
    logic [dusss_pkg::NIBBLE_W-1:0]             r_nib, n_nib;
    logic                                       w_opp;
    logic                                       w_up;
    logic                                       w_down;

    // Step decision for this tick
    always_comb begin
        w_opp  = (r_div >= i_cfg.prescale);
        w_up   = w_opp && (i_target > r_pos) && (r_pos != dusss_pkg::POS_MAX);
        w_down = w_opp && (i_target < r_pos) && (r_pos != dusss_pkg::POS_MIN);
    end

    // Next state; a disabled motor holds everything
    always_comb begin
        n_pos = r_pos;
        n_idx = r_idx;
        n_div = r_div;
        n_nib = r_nib;
        if (i_cfg.enable) begin
            n_div = w_opp ? dusss_pkg::PRESCALE_W'(1) : r_div + 1'b1;
            if (w_up || w_down) begin
                n_nib = dusss_pkg::phase_pattern(i_cfg.mode, r_idx);
            end
            if (w_up) begin
                n_idx = r_idx + 1'b1;
                n_pos = r_pos + 1'b1;
            end else if (w_down) begin
                n_idx = r_idx - 1'b1;
                n_pos = r_pos - 1'b1;
            end
        end
    end

    // Result of this tick
    always_comb begin
        o_res.nibble    = n_nib;
        o_res.pos       = n_pos;
        o_res.at_target = (n_pos == i_target);
    end

    // Advance state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_idx <= '0;
            r_div <= dusss_pkg::PRESCALE_W'(1);
            r_nib <= '0;
        end else if (i_tick) begin
            r_pos <= n_pos;
            r_idx <= n_idx;
            r_div <= n_div;
            r_nib <= n_nib;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual unipolar stepper sequencer. A table of
// directed ticks and register writes runs first, then random phases with
// fresh register settings and goal-seeking targets. Each accepted tick is
// run through a local model of both motors, and every output transfer is
// compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic signed [dusss_pkg::POSITION_BITS-1:0] t_pos;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_HOLD,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic [dusss_pkg::CFG_IDX_W-1:0]  idx;
        logic [dusss_pkg::CFG_DATA_W-1:0] data;
        dusss_pkg::t_in_item              targets;
        logic                             has_res;
        dusss_pkg::t_out_item             res;
    } t_row;

    // Enable mask values
    localparam logic [1:0] EN_NONE = 2'b00;
    localparam logic [1:0] EN_B    = 2'b10;
    localparam logic [1:0] EN_BOTH = 2'b11;

    // Register indexes with no register behind them
    localparam logic [dusss_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_FIRST =
        dusss_pkg::CFG_IDX_W'(dusss_pkg::CFG_PRESCALE_B + 1);
    localparam logic [dusss_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP =
        {dusss_pkg::CFG_IDX_W{1'b1}};

    localparam int MAX_IDLE        = 11;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RAND_PHASES     = 14;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DIR_ROWS        = 36;
    localparam int TIMEOUT_NS      = 1_000_000;

    localparam dusss_pkg::t_out_item NO_RES = '0;

    // Coil patterns: one-phase, two-phase, half-step
    localparam logic [dusss_pkg::NIBBLE_W-1:0] COIL_TAB [0:2][0:7] = '{
        '{4'h1, 4'h2, 4'h4, 4'h8, 4'h1, 4'h2, 4'h4, 4'h8},
        '{4'h3, 4'h6, 4'hC, 4'h9, 4'h3, 4'h6, 4'hC, 4'h9},
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9}
    };

    // Directed ticks and register writes
    localparam t_row DIRECTED [0:DIR_ROWS-1] = '{
        '{ROW_TICK, '0, '0, '{16'sd0, 16'sd0}, 1'b1,
          '{8'h00, 16'sd0, 16'sd0, 1'b1, 1'b1}},
        '{ROW_TICK, '0, '0, '{16'sd1, -16'sd1}, 1'b1,
          '{8'h11, 16'sd1, -16'sd1, 1'b1, 1'b1}},
        '{ROW_TICK, '0, '0, '{dusss_pkg::POS_MAX, dusss_pkg::POS_MIN}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{dusss_pkg::POS_MAX, dusss_pkg::POS_MIN}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{dusss_pkg::POS_MIN, dusss_pkg::POS_MAX}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{dusss_pkg::POS_MIN, dusss_pkg::POS_MAX}, 1'b0, NO_RES},
        '{ROW_HOLD, '0, '0, '0, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_MODE_A, {6'h00, dusss_pkg::MODE_TWO_PHASE}, '0, 1'b0,
          NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_MODE_B, {6'h00, dusss_pkg::MODE_HALF_STEP}, '0, 1'b0,
          NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd8, -16'sd8}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd8, -16'sd8}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{-16'sd8, 16'sd8}, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_MODE_A, {6'h00, dusss_pkg::MODE_SPARE}, '0, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_MODE_B, {6'h3F, dusss_pkg::MODE_SPARE}, '0, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd8, -16'sd8}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd8, -16'sd8}, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_PRESCALE_A, 8'h00, '0, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_PRESCALE_B, 8'hFF, '0, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd100, -16'sd100}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd100, -16'sd100}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd100, -16'sd100}, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_ENABLE_MASK, {6'h3F, EN_B}, '0, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{-16'sd100, 16'sd100}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{-16'sd100, 16'sd100}, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_ENABLE_MASK, {6'h00, EN_NONE}, '0, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd0, 16'sd0}, 1'b0, NO_RES},
        '{ROW_HOLD, '0, '0, '0, 1'b0, NO_RES},
        '{ROW_CFG, CFG_IDX_TOP, 8'hFF, '0, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_ENABLE_MASK, {6'h00, EN_BOTH}, '0, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_PRESCALE_A, 8'h02, '0, 1'b0, NO_RES},
        '{ROW_CFG, dusss_pkg::CFG_PRESCALE_B, 8'h01, '0, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd3, 16'sd3}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd3, 16'sd3}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd3, 16'sd3}, 1'b0, NO_RES},
        '{ROW_TICK, '0, '0, '{16'sd3, 16'sd3}, 1'b0, NO_RES},
        '{ROW_HOLD, '0, '0, '0, 1'b0, NO_RES}
    };

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    dusss_pkg::t_in_item              i_in_data  = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    dusss_pkg::t_out_item             o_out_data;
    logic                             i_cfg_we   = 1'b0;
    logic [dusss_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [dusss_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Model copy of the registers and of both motors
    logic [1:0]                       mdl_mask;
    logic [dusss_pkg::MODE_W-1:0]     mdl_mode_a, mdl_mode_b;
    logic [dusss_pkg::PRESCALE_W-1:0] mdl_presc_a, mdl_presc_b;
    t_pos                             pos_a, pos_b;
    logic [dusss_pkg::IDX_W-1:0]      idx_a, idx_b;
    logic [dusss_pkg::PRESCALE_W-1:0] div_a, div_b;
    logic [dusss_pkg::COIL_W-1:0]     coil_now;

    dusss_pkg::t_out_item coil_states_due[$];
    dusss_pkg::t_out_item want;
    int                   mismatches = 0;
    bit                   idle_on    = 1'b1;

    dual_unipolar_stepper_sequencer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // One motor's step opportunity; the index moves after its pattern is used
    function automatic void step_motor(
        input  t_pos                             tgt,
        input  logic [dusss_pkg::MODE_W-1:0]     mode,
        input  logic [dusss_pkg::PRESCALE_W-1:0] presc,
        inout  t_pos                             pos,
        inout  logic [dusss_pkg::IDX_W-1:0]      idx,
        inout  logic [dusss_pkg::PRESCALE_W-1:0] div,
        inout  logic [dusss_pkg::NIBBLE_W-1:0]   nib
    );
        int tab_row;
        if (mode == dusss_pkg::MODE_ONE_PHASE)
            tab_row = 0;
        else if (mode == dusss_pkg::MODE_TWO_PHASE)
            tab_row = 1;
        else
            tab_row = 2;
        if (div >= presc) begin
            if (tgt > pos && pos < dusss_pkg::POS_MAX) begin
                nib = COIL_TAB[tab_row][idx];
                idx = idx + 1'b1;
                pos = pos + t_pos'(1);
            end else if (tgt < pos && pos > dusss_pkg::POS_MIN) begin
                nib = COIL_TAB[tab_row][idx];
                idx = idx - 1'b1;
                pos = pos - t_pos'(1);
            end
            div = '0;
        end
        div = div + 1'b1;
    endfunction

    // Advance both motors by one tick and return the coil state it yields
    function automatic dusss_pkg::t_out_item predict_tick(input dusss_pkg::t_in_item t);
        logic [dusss_pkg::NIBBLE_W-1:0] na, nb;
        dusss_pkg::t_out_item           r;
        na = coil_now[3:0];
        nb = coil_now[7:4];
        if (mdl_mask[0])
            step_motor(t.target_a, mdl_mode_a, mdl_presc_a, pos_a, idx_a, div_a, na);
        if (mdl_mask[1])
            step_motor(t.target_b, mdl_mode_b, mdl_presc_b, pos_b, idx_b, div_b, nb);
        coil_now      = {nb, na};
        r.coil_drive  = coil_now;
        r.position_a  = pos_a;
        r.position_b  = pos_b;
        r.at_target_a = (pos_a == t.target_a);
        r.at_target_b = (pos_b == t.target_b);
        return r;
    endfunction

    // New goal near the motor, on it, or anywhere in range
    function automatic t_pos next_goal(input t_pos pos);
        int r;
        int off;
        r = $urandom_range(0, 9);
        off = int'($urandom_range(0, 48)) - 24;
        if (r == 0)
            return t_pos'($urandom);
        else if (r < 3)
            return pos;
        return t_pos'(int'(pos) + off);
    endfunction

    function automatic logic [dusss_pkg::PRESCALE_W-1:0] draw_prescale();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r < 7)
            return dusss_pkg::PRESCALE_W'($urandom_range(1, 3));
        else if (r < 9)
            return dusss_pkg::PRESCALE_W'($urandom_range(4, 12));
        return dusss_pkg::PRESCALE_W'($urandom);
    endfunction

    // Present one tick, wait for its transfer, queue the expected coil state
    task automatic send_tick(input dusss_pkg::t_in_item t, input bit typed,
                             input dusss_pkg::t_out_item typed_res);
        dusss_pkg::t_out_item p;
        int                   gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t;
        do @(posedge i_clk); while (!o_in_ready);
        p = predict_tick(t);
        coil_states_due.push_back(typed ? typed_res : p);
    endtask

    // Drop valid and wait until every expected transfer has come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (coil_states_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dusss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dusss_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            dusss_pkg::CFG_ENABLE_MASK: mdl_mask    = data[1:0];
            dusss_pkg::CFG_MODE_A:      mdl_mode_a  = data[dusss_pkg::MODE_W-1:0];
            dusss_pkg::CFG_MODE_B:      mdl_mode_b  = data[dusss_pkg::MODE_W-1:0];
            dusss_pkg::CFG_PRESCALE_A:  mdl_presc_a = data[dusss_pkg::PRESCALE_W-1:0];
            dusss_pkg::CFG_PRESCALE_B:  mdl_presc_b = data[dusss_pkg::PRESCALE_W-1:0];
            default: ;
        endcase
    endtask

    // Output side: stall a random number of cycles before each transfer
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (coil_states_due.size() == 0) begin
                $error("unexpected output transfer: coil_drive 0x%02h", o_out_data.coil_drive);
                mismatches++;
            end else begin
                want = coil_states_due.pop_front();
                if (o_out_data.coil_drive !== want.coil_drive) begin
                    $error("coil_drive: expected 0x%02h, got 0x%02h",
                           want.coil_drive, o_out_data.coil_drive);
                    mismatches++;
                end
                if (o_out_data.position_a !== want.position_a) begin
                    $error("position_a: expected %0d, got %0d",
                           want.position_a, o_out_data.position_a);
                    mismatches++;
                end
                if (o_out_data.position_b !== want.position_b) begin
                    $error("position_b: expected %0d, got %0d",
                           want.position_b, o_out_data.position_b);
                    mismatches++;
                end
                if (o_out_data.at_target_a !== want.at_target_a) begin
                    $error("at_target_a: expected %0b, got %0b",
                           want.at_target_a, o_out_data.at_target_a);
                    mismatches++;
                end
                if (o_out_data.at_target_b !== want.at_target_b) begin
                    $error("at_target_b: expected %0b, got %0b",
                           want.at_target_b, o_out_data.at_target_b);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        t_row                row;
        dusss_pkg::t_in_item tgt;
        t_pos                goal_a, goal_b;
        int                  p, k;

        mdl_mask    = EN_BOTH;
        mdl_mode_a  = dusss_pkg::MODE_ONE_PHASE;
        mdl_mode_b  = dusss_pkg::MODE_ONE_PHASE;
        mdl_presc_a = 8'd1;
        mdl_presc_b = 8'd1;
        pos_a       = '0;
        pos_b       = '0;
        idx_a       = '0;
        idx_b       = '0;
        div_a       = 8'd1;
        div_b       = 8'd1;
        coil_now    = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIRECTED[r];
            case (row.kind)
                ROW_CFG: begin
                    settle();
                    write_reg(row.idx, row.data);
                end
                ROW_HOLD: begin
                    tgt.target_a = pos_a;
                    tgt.target_b = pos_b;
                    send_tick(tgt, 1'b0, NO_RES);
                end
                default: begin
                    send_tick(row.targets, row.has_res, row.res);
                end
            endcase
        end

        // Random phases: new settings, then goal-seeking moves with some noise
        for (p = 0; p < RAND_PHASES; p++) begin
            settle();
            idle_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            write_reg(dusss_pkg::CFG_ENABLE_MASK, {6'($urandom),
                      ($urandom_range(0, 3) == 0) ? 2'($urandom) : EN_BOTH});
            write_reg(dusss_pkg::CFG_MODE_A, {6'($urandom), 2'($urandom)});
            write_reg(dusss_pkg::CFG_MODE_B, {6'($urandom), 2'($urandom)});
            write_reg(dusss_pkg::CFG_PRESCALE_A,
                      (p == 1) ? 8'h00 : (p == 2) ? 8'hFF : draw_prescale());
            write_reg(dusss_pkg::CFG_PRESCALE_B, (p == 1) ? 8'h00 : draw_prescale());
            if ($urandom_range(0, 3) == 0)
                write_reg(dusss_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_TOP,
                                                               CFG_IDX_SPARE_FIRST)),
                          8'($urandom));
            goal_a = pos_a;
            goal_b = pos_b;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 7) == 0)
                    goal_a = next_goal(pos_a);
                if ($urandom_range(0, 7) == 0)
                    goal_b = next_goal(pos_b);
                tgt.target_a = goal_a;
                tgt.target_b = goal_b;
                if ($urandom_range(0, 19) == 0)
                    tgt = dusss_pkg::t_in_item'($urandom);
                send_tick(tgt, 1'b0, NO_RES);
            end
        end

        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
